// ===== rtl/melody_tone_sequencer_core_defines.svh =====
// assertion macros shared by the melody tone sequencer rtl
// expects signals named clk and rst in the scope of each use
`ifndef MELODY_TONE_SEQUENCER_CORE_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// types, codes and tables of the melody tone sequencer
// no dependencies
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned DEF_SONG_DEPTH = 256;
  localparam int unsigned DEF_XTAL_HZ    = 11030000;

  localparam int unsigned NOTE_COUNT = 22;
  localparam int unsigned FREQ_W     = 11;
  localparam int unsigned LEN_W      = 17;

  localparam logic       CMD_TICK  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;
  localparam logic [7:0] REST_CODE = 8'd22;
  localparam logic [7:0] END_CODE  = 8'hFF;
  localparam logic [4:0] REST_INDEX = 5'd21;

  localparam logic [15:0] RESET_RELOAD = 16'hFF00;

  // note frequencies in hz, middle octave, high octave, low octave, then rest
  localparam logic [FREQ_W-1:0] TONE_FREQ [NOTE_COUNT] = '{
    11'd523,  11'd587,  11'd659,  11'd698,  11'd784,  11'd880,  11'd988,
    11'd1047, 11'd1175, 11'd1319, 11'd1397, 11'd1568, 11'd1760, 11'd1976,
    11'd262,  11'd294,  11'd330,  11'd349,  11'd392,  11'd440,  11'd494,
    11'd300
  };

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [15:0] data;
  } wr_req_t;

  typedef struct packed {
    logic       buzzer;
    logic [4:0] note_index;
    logic [7:0] position;
    logic       song_end;
  } result_t;

endpackage

// ===== rtl/mts_in_if.sv =====
// request channel of the melody tone sequencer: ticks and song writes
// no dependencies
`timescale 1ns / 1ps

interface mts_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] entry_addr;
  logic [7:0] entry_pitch;
  logic [7:0] entry_beat;

  modport source (output valid, cmd, entry_addr, entry_pitch, entry_beat, input ready);
  modport sink   (input valid, cmd, entry_addr, entry_pitch, entry_beat, output ready);
endinterface

// ===== rtl/mts_out_if.sv =====
// result channel of the melody tone sequencer
// no dependencies
`timescale 1ns / 1ps

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer;
  logic [4:0] note_index;
  logic [7:0] position;
  logic       song_end;

  modport source (output valid, buzzer, note_index, position, song_end, input ready);
  modport sink   (input valid, buzzer, note_index, position, song_end, output ready);
endinterface

// ===== rtl/mts_song_mem.sv =====
// song memory: one write port, one registered read port with write forwarding
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_song_mem #(
  parameter int unsigned SONG_DEPTH = mts_pkg::DEF_SONG_DEPTH,
  parameter int unsigned ADDR_W     = $clog2(SONG_DEPTH)
) (
  input  logic                clk,
  input  mts_pkg::wr_req_t    wr,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [15:0]         rd_data
);

  localparam int unsigned WIDE_W = (ADDR_W > 8) ? ADDR_W : 8;

  logic [15:0]       mem [SONG_DEPTH];
  logic [WIDE_W-1:0] wr_wide;
  logic [ADDR_W-1:0] wr_addr;

  assign wr_wide = WIDE_W'(wr.addr);
  assign wr_addr = wr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // read data always shows the entry as it stands after this cycle's write
  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mts_tone_seq.sv =====
// tone counter, buzzer and note sequencer state with next-state logic
// depends on mts_pkg and melody_tone_sequencer_core_defines.svh
`timescale 1ns / 1ps

`include "melody_tone_sequencer_core_defines.svh"

module mts_tone_seq #(
  parameter int unsigned SONG_DEPTH = mts_pkg::DEF_SONG_DEPTH,
  parameter int unsigned XTAL_HZ    = mts_pkg::DEF_XTAL_HZ,
  parameter int unsigned ADDR_W     = $clog2(SONG_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              play,
  input  logic [15:0]       entry,
  output logic [ADDR_W-1:0] rd_addr,
  output mts_pkg::result_t  res_next
);

  localparam int unsigned TICK_BASE = XTAL_HZ / 24;
  localparam int unsigned POS_W     = (ADDR_W > 8) ? ADDR_W : 8;
  localparam int unsigned LEN_W     = mts_pkg::LEN_W;
  localparam int unsigned PROD_W    = 8 + mts_pkg::FREQ_W;

  localparam logic [15:0] RELOAD_TAB [mts_pkg::NOTE_COUNT] = '{
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[0]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[1]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[2]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[3]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[4]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[5]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[6]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[7]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[8]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[9]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[10]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[11]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[12]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[13]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[14]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[15]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[16]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[17]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[18]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[19]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[20]),
    16'(32'd65536 - TICK_BASE / mts_pkg::TONE_FREQ[21])
  };

  logic [15:0]       reload,   reload_next;
  logic [15:0]       cnt,      cnt_next;
  logic              buzzer,   buzzer_next;
  logic              sound_on, sound_on_next;
  logic [ADDR_W-1:0] pos,      pos_next;
  logic [LEN_W-1:0]  elapsed,  elapsed_next;
  logic [LEN_W-1:0]  note_len, note_len_next;
  logic [LEN_W-1:0]  sound_len, sound_len_next;
  logic [4:0]        cur_note, cur_note_next;

  logic              ovf;
  logic              ended;
  logic [7:0]        pitch;
  logic [7:0]        beat;
  logic [4:0]        idx;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  len_new;
  logic [LEN_W-1:0]  elapsed_inc;
  logic [POS_W-1:0]  pos_wide;

  assign pitch       = entry[15:8];
  assign beat        = entry[7:0];
  assign ovf         = (cnt == 16'hFFFF);
  assign elapsed_inc = elapsed + LEN_W'(1);

  always_comb begin
    if (pitch inside {[8'd1:mts_pkg::REST_CODE]}) begin
      idx = 5'(pitch - 8'd1);
    end else begin
      idx = mts_pkg::REST_INDEX;
    end
  end

  assign prod    = PROD_W'(beat) * PROD_W'(mts_pkg::TONE_FREQ[idx]);
  assign len_new = prod[PROD_W-1:2];

  always_comb begin
    reload_next    = reload;
    cnt_next       = cnt;
    buzzer_next    = buzzer;
    sound_on_next  = sound_on;
    pos_next       = pos;
    elapsed_next   = elapsed;
    note_len_next  = note_len;
    sound_len_next = sound_len;
    cur_note_next  = cur_note;
    ended          = 1'b0;
    if (tick && !play) begin
      buzzer_next = 1'b1;
    end else if (tick) begin
      cnt_next = cnt + 16'd1;
      if (ovf) begin
        cnt_next    = reload;
        buzzer_next = sound_on ? ~buzzer : 1'b1;
        if (elapsed == '0) begin
          if (pitch == mts_pkg::END_CODE) begin
            pos_next       = '0;
            note_len_next  = '0;
            sound_len_next = '0;
            ended          = 1'b1;
          end else begin
            cur_note_next  = idx;
            reload_next    = RELOAD_TAB[idx];
            note_len_next  = len_new;
            sound_len_next = len_new - (len_new >> 2);
            sound_on_next  = (idx != mts_pkg::REST_INDEX);
            elapsed_next   = LEN_W'(1);
          end
        end else if (elapsed >= note_len) begin
          elapsed_next = '0;
          pos_next     = (pos == ADDR_W'(SONG_DEPTH - 1)) ? '0 : pos + ADDR_W'(1);
        end else begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc == sound_len) begin
            sound_on_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload    <= mts_pkg::RESET_RELOAD;
      cnt       <= mts_pkg::RESET_RELOAD;
      buzzer    <= 1'b1;
      sound_on  <= 1'b0;
      pos       <= '0;
      elapsed   <= '0;
      note_len  <= '0;
      sound_len <= '0;
      cur_note  <= '0;
    end else begin
      reload    <= reload_next;
      cnt       <= cnt_next;
      buzzer    <= buzzer_next;
      sound_on  <= sound_on_next;
      pos       <= pos_next;
      elapsed   <= elapsed_next;
      note_len  <= note_len_next;
      sound_len <= sound_len_next;
      cur_note  <= cur_note_next;
    end
  end

  // prefetch the entry that the next tick may start
  assign rd_addr = rst ? '0 : pos_next;

  assign pos_wide            = POS_W'(pos_next);
  assign res_next.buzzer     = buzzer_next;
  assign res_next.note_index = cur_note_next;
  assign res_next.position   = pos_wide[7:0];
  assign res_next.song_end   = ended;

  `MTS_ASSERT_NEXT(a_end_wraps, ended, pos == '0, "end marker did not wrap position")
  `MTS_ASSERT_NEXT(a_hold_buzzer_high, tick && !play, buzzer && $stable(cnt), "paused tick moved counter or buzzer low")
  `MTS_ASSERT_NOW(a_rest_silent, sound_on, cur_note != mts_pkg::REST_INDEX, "sound on during a rest")
  `MTS_ASSERT_NEXT(a_idle_holds, !tick, $stable(cnt) && $stable(elapsed) && $stable(pos), "state moved without a tick")

endmodule

// ===== rtl/melody_tone_sequencer_core.sv =====
// top level of the melody tone sequencer: channels, play register, result register
// depends on mts_pkg, mts_in_if, mts_out_if, mts_song_mem, mts_tone_seq
`timescale 1ns / 1ps

// Melody player. Each request on in_ch is either one base clock tick (cmd 0) or a
// write of one song entry (cmd 1: pitch in the high byte, beat in quarter beats in
// the low byte). While play is 1, every tick advances a 16-bit tone counter; on its
// overflow the counter reloads from the current note's value, the buzzer toggles
// (or goes high when the sound is off) and the note sequencer steps: it starts a
// new entry, counts overflows up to beat * freq / 4, cuts the sound at three
// quarters of that, and moves on. Pitch 1..21 are notes, 22 and unknown codes are
// rests, 255 wraps the song to entry 0 and raises song_end on that result. With
// play 0 ticks hold everything and drive the buzzer high. Every request produces
// exactly one result on out_ch. One request is taken per clock cycle unless out_ch
// stalls; its result appears in the output register on the next cycle. The rate is
// set by the single pass through the counter compare, the prefetched song memory
// read and the beat-by-frequency multiplier. The song memory has no clearing pass
// after reset: entries must be written before the song reaches them. play is
// written through cfg_we / cfg_wdata while the block is idle, a rule left to the user.
module melody_tone_sequencer_core #(
  parameter int unsigned SONG_DEPTH = mts_pkg::DEF_SONG_DEPTH,
  parameter int unsigned XTAL_HZ    = mts_pkg::DEF_XTAL_HZ
) (
  input  logic      clk,
  input  logic      rst,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(SONG_DEPTH);

  logic                play;
  logic                in_ready;
  logic                accept;
  logic                tick;
  logic                out_valid;
  mts_pkg::result_t    res_next;
  mts_pkg::result_t    res;
  mts_pkg::wr_req_t    wr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [15:0]         rd_data;

  // play register, to be written only while idle, a rule left to the user
  always_ff @(posedge clk) begin
    if (rst) begin
      play <= 1'b0;
    end else if (cfg_we) begin
      play <= cfg_wdata;
    end
  end

  // take a new request whenever the result register is empty or draining
  assign in_ready    = !rst && (!out_valid || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign tick        = accept && (in_ch.cmd == mts_pkg::CMD_TICK);

  // song writes beyond the memory are dropped
  assign wr.en   = accept && (in_ch.cmd == mts_pkg::CMD_WRITE) &&
                   (32'(in_ch.entry_addr) < 32'(SONG_DEPTH));
  assign wr.addr = in_ch.entry_addr;
  assign wr.data = {in_ch.entry_pitch, in_ch.entry_beat};

  mts_song_mem #(
    .SONG_DEPTH (SONG_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mts_tone_seq #(
    .SONG_DEPTH (SONG_DEPTH),
    .XTAL_HZ    (XTAL_HZ),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .play     (play),
    .entry    (rd_data),
    .rd_addr  (rd_addr),
    .res_next (res_next)
  );

  // result register: holds the state after the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.buzzer     = res.buzzer;
  assign out_ch.note_index = res.note_index;
  assign out_ch.position   = res.position;
  assign out_ch.song_end   = res.song_end;

endmodule

// ===== sim/melody_tone_sequencer_core_tb.sv =====
// self-checking testbench of melody_tone_sequencer_core: random ticks and song writes
// checked against an in-bench player model. depends on mts_pkg, mts_in_if, mts_out_if
`timescale 1ns / 1ps

module melody_tone_sequencer_core_tb;

  // cycles with no request and no result moving before the run is called dead
  localparam int unsigned STALL_LIMIT = 5000;
  // ticks per burst while waiting for the song to reach a given point
  localparam int unsigned CHUNK       = 8;
  // bursts allowed per wait, far above the longest overflow spacing used here
  localparam int unsigned RUN_CAP     = 100;
  // ticks spent inside the final rest note
  localparam int unsigned TAIL_TICKS  = 200;
  // window of cycles in which neither side idles
  localparam int unsigned CALM_FROM   = 300;
  localparam int unsigned CALM_TO     = 700;

  typedef struct packed {
    logic       cmd;
    logic [7:0] addr;
    logic [7:0] pitch;
    logic [7:0] beat;
  } tone_req_t;

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      cfg_we     = 1'b0;
  logic      cfg_wdata  = 1'b0;
  logic      drv_valid  = 1'b0;
  tone_req_t drv_req    = '0;
  logic      sink_ready = 1'b0;

  int unsigned cyc      = 0;
  int unsigned stall_n  = 0;
  logic        calm;

  // pending requests, and the results the player model says they cause
  tone_req_t        tone_requests [$];
  mts_pkg::result_t expected_tones [$];
  mts_pkg::result_t seen_tone;
  mts_pkg::result_t want_tone;

  // player model state, reset values of the block
  logic [15:0] song_q [256];
  logic [15:0] reload_q  = mts_pkg::RESET_RELOAD;
  logic [15:0] count_q   = mts_pkg::RESET_RELOAD;
  logic        buzz_q    = 1'b1;
  logic        sound_q   = 1'b0;
  logic [7:0]  pos_q     = '0;
  logic [16:0] elapsed_q = '0;
  logic [16:0] length_q  = '0;
  logic [16:0] cut_q     = '0;
  logic [4:0]  note_q    = '0;
  logic        play_q    = 1'b0;

  // run statistics
  int unsigned accepted_n = 0;
  int unsigned checked_n  = 0;
  int unsigned overflow_n = 0;
  int unsigned end_n      = 0;
  int unsigned wrap_n     = 0;
  int unsigned errors     = 0;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.cmd         = drv_req.cmd;
  assign in_ch.entry_addr  = drv_req.addr;
  assign in_ch.entry_pitch = drv_req.pitch;
  assign in_ch.entry_beat  = drv_req.beat;
  assign out_ch.ready      = sink_ready;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  melody_tone_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one accepted request through the player: tone counter, buzzer, note sequencer
  function automatic void advance_player(tone_req_t r);
    mts_pkg::result_t res;
    logic [15:0]      ent;
    logic [4:0]       idx;
    int unsigned      freq;
    res.song_end = 1'b0;
    if (r.cmd == mts_pkg::CMD_WRITE) begin
      // a write only touches the song memory
      song_q[r.addr] = {r.pitch, r.beat};
    end else if (!play_q) begin
      // stopped: everything holds, buzzer forced high
      buzz_q = 1'b1;
    end else begin
      count_q = count_q + 16'd1;
      if (count_q == 16'd0) begin
        overflow_n++;
        count_q = reload_q;
        buzz_q  = sound_q ? ~buzz_q : 1'b1;
        if (elapsed_q == '0) begin
          // start of an entry
          ent = song_q[pos_q];
          if (ent[15:8] == mts_pkg::END_CODE) begin
            // end marker: back to entry 0, lengths cleared, the rest untouched
            pos_q        = '0;
            length_q     = '0;
            cut_q        = '0;
            res.song_end = 1'b1;
            end_n++;
          end else begin
            // codes outside 1..22 play as a rest
            idx = (ent[15:8] >= 8'd1 && ent[15:8] <= mts_pkg::REST_CODE) ?
                  5'(ent[15:8] - 8'd1) : mts_pkg::REST_INDEX;
            freq      = 32'(mts_pkg::TONE_FREQ[idx]);
            note_q    = idx;
            reload_q  = 16'(32'd65536 - (mts_pkg::DEF_XTAL_HZ / 12) / (freq * 2));
            length_q  = 17'((ent[7:0] * freq) >> 2);
            // sound is cut at three quarters of the note
            cut_q     = length_q - (length_q >> 2);
            sound_q   = (idx != mts_pkg::REST_INDEX);
            elapsed_q = 17'd1;
          end
        end else if (elapsed_q >= length_q) begin
          // note done, next entry, wrapping at the memory end
          elapsed_q = '0;
          pos_q     = pos_q + 8'd1;
          if (pos_q == 8'd0) wrap_n++;
        end else begin
          elapsed_q = elapsed_q + 17'd1;
          if (elapsed_q == cut_q) sound_q = 1'b0;
        end
      end
    end
    res.buzzer     = buzz_q;
    res.note_index = note_q;
    res.position   = pos_q;
    expected_tones.push_back(res);
  endfunction

  // driver: presents the oldest pending request, holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        advance_player(drv_req);
        tone_requests.delete(0);
        accepted_n++;
      end
      // a new request may go out only when the line is free or was just taken
      if (!drv_valid || in_ch.ready) begin
        if (tone_requests.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          drv_valid <= 1'b1;
          drv_req   <= tone_requests[0];
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result taken is held against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        seen_tone = '{buzzer: out_ch.buzzer, note_index: out_ch.note_index,
                      position: out_ch.position, song_end: out_ch.song_end};
        if (expected_tones.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: buzzer %0b note %0d pos %0d end %0b",
                     seen_tone.buzzer, seen_tone.note_index, seen_tone.position,
                     seen_tone.song_end);
        end else begin
          want_tone = expected_tones.pop_front();
          checked_n++;
          if (want_tone.buzzer !== seen_tone.buzzer ||
              want_tone.note_index !== seen_tone.note_index ||
              want_tone.position !== seen_tone.position ||
              want_tone.song_end !== seen_tone.song_end) begin
            errors++;
            if (errors <= 10)
              $display({"result %0d: expected buzzer %0b note %0d pos %0d end %0b,",
                        " got %0b %0d %0d %0b"},
                       checked_n, want_tone.buzzer, want_tone.note_index,
                       want_tone.position, want_tone.song_end, seen_tone.buzzer,
                       seen_tone.note_index, seen_tone.position, seen_tone.song_end);
          end
        end
      end
      sink_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (drv_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
      stall_n <= 0;
    end else if (stall_n == STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_n <= stall_n + 1;
    end
  end

  task automatic push_write(input logic [7:0] a, input logic [7:0] p, input logic [7:0] b);
    tone_requests.push_back('{cmd: mts_pkg::CMD_WRITE, addr: a, pitch: p, beat: b});
  endtask

  // n ticks with random idle fields
  task automatic tick_burst(input int unsigned n);
    tone_req_t r;
    for (int unsigned k = 0; k < n; k++) begin
      r.cmd   = mts_pkg::CMD_TICK;
      r.addr  = 8'($urandom);
      r.pitch = 8'($urandom);
      r.beat  = 8'($urandom);
      tone_requests.push_back(r);
    end
  endtask

  task automatic wait_idle();
    while (tone_requests.size() != 0 || expected_tones.size() != 0) @(posedge clk);
  endtask

  // ticks in small bursts until the model has seen the given number of overflows
  task automatic run_to_overflow(input int unsigned target);
    int unsigned tries;
    tries = 0;
    while (overflow_n < target && tries < RUN_CAP) begin
      tick_burst(CHUNK);
      wait_idle();
      tries++;
    end
  endtask

  // play register write, only with nothing in flight
  task automatic set_play(input logic v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    play_q    = v;
  endtask

  initial begin
    logic [7:0]  p;
    int unsigned pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // stopped after reset: ticks hold everything, writes only fill memory
    tick_burst(3);
    push_write(8'd255, mts_pkg::END_CODE, 8'd255);
    // top note with zero beat, then the end marker
    push_write(8'd0, 8'd14, 8'd0);
    push_write(8'd1, mts_pkg::END_CODE, 8'($urandom_range(255)));
    tick_burst(2);

    // first overflow starts entry 0, the second moves on, the third meets the end
    set_play(1'b1);
    run_to_overflow(3);

    // stop after the wrap and rewrite entry 0, the one being fetched, as a rest
    set_play(1'b0);
    tick_burst(4);
    pick = $urandom_range(3);
    if (pick == 0)      p = 8'd0;
    else if (pick == 1) p = mts_pkg::REST_CODE;
    else if (pick == 2) p = 8'd23;
    else                p = 8'd254;
    push_write(8'd0, p, 8'($urandom_range(255)));
    tick_burst(3);

    // restart: the sounding note ends on the next overflow, which starts the rest
    set_play(1'b1);
    run_to_overflow(4);
    tick_burst(TAIL_TICKS);

    // drain, then a few quiet cycles for anything stray
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d checked results over %0d tone overflows",
             accepted_n, checked_n, overflow_n);
    $display("song ends %0d, position wraps %0d, mismatches %0d", end_n, wrap_n, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
